// ===== rtl/u8s_pkg.sv =====
`timescale 1ns / 1ps

package u8s_pkg;

  // Replacement for any byte that cannot stand in the output
  localparam logic [7:0] QMARK = 8'h3F;

  // Lead and continuation byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] MASK2       = 8'hE0;
  localparam logic [7:0] LEAD2       = 8'hC0;
  localparam logic [7:0] MASK3       = 8'hF0;
  localparam logic [7:0] LEAD3       = 8'hE0;
  localparam logic [7:0] MASK4       = 8'hF8;
  localparam logic [7:0] LEAD4       = 8'hF0;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_BITS   = 8'h80;

  localparam int unsigned HOLD_DEPTH = 4;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // append the accepted byte to the hold buffer
    logic step;  // emit one output byte and drop the front byte
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stop;       // nothing more to emit for this request
    logic slot_free;  // output register can take a byte this cycle
    logic last;       // the byte emitted by a step ends this request
  } status_t;

  // Sequence length set by a lead byte, zero for an invalid lead
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    if (lead < ASCII_LIMIT) len = 3'd1;
    else if ((lead & MASK2) == LEAD2) len = 3'd2;
    else if ((lead & MASK3) == LEAD3) len = 3'd3;
    else if ((lead & MASK4) == LEAD4) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_BITS;
  endfunction

endpackage

// ===== rtl/u8s_in_if.sv =====
`timescale 1ns / 1ps

interface u8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

// ===== rtl/u8s_out_if.sv =====
`timescale 1ns / 1ps

interface u8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, output out_byte, output run_last, output text_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input text_done,
                  output ready);
endinterface

// ===== rtl/u8s_datapath.sv =====
`timescale 1ns / 1ps

module u8s_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  u8s_pkg::cmd_t    cmd_i,
  output u8s_pkg::status_t status_o,
  input  logic [7:0]       in_byte_i,
  input  logic             text_end_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             text_done_o
);

  logic [7:0] held_q [u8s_pkg::HOLD_DEPTH];
  logic [7:0] held_d [u8s_pkg::HOLD_DEPTH];
  logic [2:0] count_q, count_d;
  logic [1:0] pass_q, pass_d;
  logic       flush_q, flush_d;
  logic       end_q, end_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       run_last_q, run_last_d;
  logic       text_done_q, text_done_d;

  logic [2:0] len;
  logic [2:0] len_n;
  logic       cont_ok;
  logic       short;
  logic [7:0] emit_byte;
  logic [1:0] pass_n;
  logic       flush_n;
  logic [2:0] count_n;
  logic       last;

  // Classify the sequence at the front of the hold buffer
  always_comb begin
    len     = u8s_pkg::seq_len(held_q[0]);
    cont_ok = (len < 3'd2 || u8s_pkg::is_cont(held_q[1])) &&
              (len < 3'd3 || u8s_pkg::is_cont(held_q[2])) &&
              (len < 3'd4 || u8s_pkg::is_cont(held_q[3]));
    short   = (len != 3'd0) && (len > count_q);
  end

  // Pick the byte to emit and the state after dropping the front byte
  always_comb begin
    emit_byte = u8s_pkg::QMARK;
    pass_n    = 2'd0;
    flush_n   = flush_q;
    if (pass_q != 2'd0) begin
      emit_byte = held_q[0];
      pass_n    = pass_q - 2'd1;
    end else if (flush_q || len == 3'd0) begin
      emit_byte = u8s_pkg::QMARK;
    end else if (short) begin
      // cut short by text end: the whole remainder becomes '?'
      emit_byte = u8s_pkg::QMARK;
      flush_n   = 1'b1;
    end else if (cont_ok) begin
      emit_byte = held_q[0];
      pass_n    = 2'(len - 3'd1);
    end
    count_n = count_q - 3'd1;
    len_n   = u8s_pkg::seq_len(held_q[1]);
    last    = (count_n == 3'd0) ||
              (!end_q && pass_n == 2'd0 && len_n != 3'd0 && len_n > count_n);
  end

  always_comb begin
    status_o.stop      = (count_q == 3'd0) ||
                         (pass_q == 2'd0 && !flush_q && !end_q && short);
    status_o.slot_free = !out_valid_q || out_ready_i;
    status_o.last      = last;
  end

  // Next state: append on load, shift and emit on step
  always_comb begin
    held_d      = held_q;
    count_d     = count_q;
    pass_d      = pass_q;
    flush_d     = flush_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    text_done_d = text_done_q;
    if (cmd_i.load) begin
      held_d[count_q[1:0]] = in_byte_i;
      count_d              = count_q + 3'd1;
      end_d                = text_end_i;
    end else if (cmd_i.step) begin
      for (int i = 0; i < u8s_pkg::HOLD_DEPTH - 1; i++) begin
        held_d[i] = held_q[i+1];
      end
      count_d     = count_n;
      pass_d      = pass_n;
      flush_d     = flush_n && (count_n != 3'd0);
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      run_last_d  = last;
      text_done_d = last && end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 3'd0;
      pass_q      <= 2'd0;
      flush_q     <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pass_q      <= pass_d;
      flush_q     <= flush_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk_i) begin
    held_q      <= held_d;
    out_byte_q  <= out_byte_d;
    run_last_q  <= run_last_d;
    text_done_q <= text_done_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign text_done_o = text_done_q;

  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> count_q < 3'd4)
    else $error("byte loaded into a full hold buffer");

  a_pass_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_q != 2'd0 |-> {1'b0, pass_q} <= count_q)
    else $error("pending pass-through exceeds held bytes");

  a_flush_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> end_q && count_q != 3'd0)
    else $error("flush active without text end");

  a_step_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !status_o.stop && status_o.slot_free && !cmd_i.load)
    else $error("step issued with nothing to emit or no output room");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && text_done_q |-> run_last_q)
    else $error("text done flagged on a byte that does not end its request");

endmodule

// ===== rtl/u8s_ctrl.sv =====
`timescale 1ns / 1ps

module u8s_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  u8s_pkg::status_t status_i,
  output u8s_pkg::cmd_t    cmd_o
);

  u8s_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u8s_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Take a request in idle, then emit one byte per cycle while output has room
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      u8s_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = u8s_pkg::ST_RUN;
        end
      end
      u8s_pkg::ST_RUN: begin
        if (status_i.stop) begin
          state_d = u8s_pkg::ST_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last) state_d = u8s_pkg::ST_IDLE;
        end
      end
      default: state_d = u8s_pkg::ST_IDLE;
    endcase
  end

  a_run_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == u8s_pkg::ST_RUN)
    else $error("load not followed by run");

endmodule

// ===== rtl/utf8_stream_sanitizer_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Payload                          Handshake
// in_i      in    in_byte[7:0], text_end           valid/ready
// out_o     out   out_byte[7:0], run_last, text_done valid/ready
//
// A request is accepted in the idle state, then emits 0 to 4 output bytes,
// one byte per cycle by the controller's run state while the output register has room.
// A byte that only extends an incomplete sequence returns to idle without emitting a byte.
// The output register lets a new request be accepted while a result waits.
// The run state stalls while the output register is full and not taken.
// Reset clears the controller, the held count and the output valid.

module utf8_stream_sanitizer_core (
  input  logic clk_i,
  input  logic rst_ni,
  u8s_in_if.sink    in_i,
  u8s_out_if.source out_o
);

  u8s_pkg::cmd_t    cmd;
  u8s_pkg::status_t status;

  u8s_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  u8s_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_byte_i   (in_i.in_byte),
    .text_end_i  (in_i.text_end),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last),
    .text_done_o (out_o.text_done)
  );

endmodule
